/* design/assert_macros.svh */
// assertion macros shared by the encoder's rtl
// no dependencies; assumes clk and rst are in scope where used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is held
`define TRRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every rising edge, also during reset
`define TRRE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/trre_pkg.sv */
// shared types and constants of the transparent-run rle encoder
// no dependencies
package trre_pkg;

  localparam int COLOR_W = 24;
  localparam int CNT_W   = 6;   // width of column and run counts and of the row_width field
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;

  localparam logic [KIND_W-1:0] KIND_TCOUNT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OCOUNT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ROWEND = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR = 2'd1;

  localparam logic [CNT_W-1:0]   ROW_WIDTH_RESET = 6'd32;
  localparam logic [COLOR_W-1:0] KEY_COLOR_RESET = 24'hFF00FF;

  // words one accepted pixel causes, emitted in field order
  typedef struct packed {
    logic             t_en;
    logic [CNT_W-1:0] t_cnt;
    logic             f_en;
    logic [CNT_W-1:0] f_cnt;
    logic             f_bank;
    logic             r_en;
  } cmd_t;

  // back end hands a drained buffer bank back to the front end
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

/* design/trre_ram.sv */
// generic single write port ram with registered read
// no dependencies
module trre_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/trre_front.sv */
// front end: config registers, pixel intake, run tracking, buffer writes
// depends on trre_pkg
module trre_front #(
  parameter int MAX_WIDTH = 32,
  parameter int AW = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [trre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trre_pkg::COLOR_W-1:0]   cfg_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [trre_pkg::COLOR_W-1:0]   s_tdata,
  input  logic                        q_full,
  output logic                        push,
  output trre_pkg::cmd_t              push_data,
  output logic                        ram_we,
  output logic                        ram_wbank,
  output logic [AW-1:0]               ram_widx,
  output logic [trre_pkg::COLOR_W-1:0]   ram_wdata,
  input  trre_pkg::release_t          rel,
  output logic [1:0]                  pending
);

  localparam logic [trre_pkg::CNT_W-1:0] MAX_W = trre_pkg::CNT_W'(MAX_WIDTH);

  logic [trre_pkg::CNT_W-1:0]   row_width;
  logic [trre_pkg::COLOR_W-1:0] key_color;
  logic [trre_pkg::CNT_W-1:0]   column, column_next;
  logic [trre_pkg::CNT_W-1:0]   run_length, run_length_next;
  logic                         in_run, in_run_next;
  logic                         had_opaque, had_opaque_next;
  logic                         cur_bank;
  logic [1:0]                   pending_next;

  logic [trre_pkg::CNT_W-1:0] eff_w;
  logic [trre_pkg::CNT_W-1:0] column_inc;
  logic [trre_pkg::CNT_W-1:0] rl_after;
  logic                       accept, opaque, row_end, start;
  trre_pkg::cmd_t             cmd;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full && (in_run || !pending[cur_bank]);
  assign accept    = s_tvalid && s_tready;

  assign eff_w = (row_width == '0) ? trre_pkg::CNT_W'(1) :
                 (row_width > MAX_W) ? MAX_W : row_width;

  assign opaque     = (s_tdata != key_color);
  assign start      = opaque && !in_run;
  assign column_inc = column + trre_pkg::CNT_W'(1);
  assign row_end    = (column_inc >= eff_w);

  always_comb begin
    cmd             = '0;
    rl_after        = run_length + trre_pkg::CNT_W'(1);
    in_run_next     = in_run;
    had_opaque_next = had_opaque;
    if (opaque) begin
      cmd.t_en        = start;
      cmd.t_cnt       = run_length;
      rl_after        = start ? trre_pkg::CNT_W'(1) : run_length + trre_pkg::CNT_W'(1);
      in_run_next     = 1'b1;
      had_opaque_next = 1'b1;
      cmd.f_en        = row_end;
      cmd.f_cnt       = rl_after;
    end else begin
      cmd.f_en    = in_run;
      cmd.f_cnt   = run_length;
      rl_after    = in_run ? trre_pkg::CNT_W'(1) : run_length + trre_pkg::CNT_W'(1);
      in_run_next = 1'b0;
      // all-transparent row reports its pixel count
      cmd.t_en    = row_end && !had_opaque;
      cmd.t_cnt   = rl_after;
    end
    cmd.f_bank = cur_bank;
    cmd.r_en   = row_end;

    if (row_end) begin
      column_next     = '0;
      run_length_next = '0;
      in_run_next     = 1'b0;
      had_opaque_next = 1'b0;
    end else begin
      column_next     = column_inc;
      run_length_next = rl_after;
    end
  end

  assign push      = accept && (cmd.t_en || cmd.f_en || cmd.r_en);
  assign push_data = cmd;
  assign ram_we    = accept && opaque;
  assign ram_wbank = cur_bank;
  assign ram_widx  = start ? '0 : run_length[AW-1:0];
  assign ram_wdata = s_tdata;

  always_comb begin
    pending_next = pending;
    if (rel.valid) begin
      pending_next[rel.bank] = 1'b0;
    end
    if (accept && cmd.f_en) begin
      pending_next[cur_bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width  <= trre_pkg::ROW_WIDTH_RESET;
      key_color  <= trre_pkg::KEY_COLOR_RESET;
      column     <= '0;
      run_length <= '0;
      in_run     <= 1'b0;
      had_opaque <= 1'b0;
      cur_bank   <= 1'b0;
      pending    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          trre_pkg::REG_ROW_WIDTH: row_width <= cfg_data[trre_pkg::CNT_W-1:0];
          trre_pkg::REG_KEY_COLOR: key_color <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        column     <= column_next;
        run_length <= run_length_next;
        in_run     <= in_run_next;
        had_opaque <= had_opaque_next;
        if (cmd.f_en) begin
          cur_bank <= !cur_bank;
        end
      end
      pending <= pending_next;
    end
  end

endmodule

/* design/trre_queue.sv */
// short command queue between the front and back ends
// depends on trre_pkg
module trre_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  trre_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output trre_pkg::cmd_t head
);

  trre_pkg::cmd_t                entry [trre_pkg::Q_DEPTH];
  logic [trre_pkg::Q_PTR_W-1:0]  wptr, rptr;
  logic [trre_pkg::Q_PTR_W:0]    count;

  assign full  = (count == (trre_pkg::Q_PTR_W+1)'(trre_pkg::Q_DEPTH));
  assign avail = (count != '0);
  assign head  = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + trre_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + trre_pkg::Q_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (trre_pkg::Q_PTR_W+1)'(1);
        2'b01:   count <= count - (trre_pkg::Q_PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/trre_back.sv */
// back end: walks one command into words, reads buffered pixels, output register
// depends on trre_pkg
module trre_back #(
  parameter int AW = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_avail,
  input  trre_pkg::cmd_t               q_head,
  output logic                         q_pop,
  output logic                         ram_rbank,
  output logic [AW-1:0]                ram_ridx,
  input  logic [trre_pkg::COLOR_W-1:0] ram_rdata,
  output trre_pkg::release_t           rel,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [trre_pkg::COLOR_W-1:0] m_tdata,
  output logic [trre_pkg::KIND_W-1:0]  m_tuser,
  output logic                         m_tlast
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TCNT = 3'd1;
  localparam logic [2:0] ST_OCNT = 3'd2;
  localparam logic [2:0] ST_PIX  = 3'd3;
  localparam logic [2:0] ST_REND = 3'd4;

  logic [2:0]                 state, state_next;
  trre_pkg::cmd_t             cmd, cmd_next;
  logic [trre_pkg::CNT_W-1:0] idx, idx_next;
  logic                       can_load, emit, emit_last;
  logic [trre_pkg::COLOR_W-1:0] emit_word;
  logic [trre_pkg::KIND_W-1:0]  emit_kind;
  logic                       pix_done;

  assign can_load = !m_tvalid || m_tready;
  assign pix_done = ((idx + trre_pkg::CNT_W'(1)) == cmd.f_cnt);

  always_comb begin
    state_next = state;
    cmd_next   = cmd;
    idx_next   = idx;
    q_pop      = 1'b0;
    emit       = 1'b0;
    emit_word  = '0;
    emit_kind  = trre_pkg::KIND_ROWEND;
    emit_last  = 1'b0;
    rel        = '0;
    case (state)
      ST_IDLE: begin
        if (q_avail) begin
          q_pop    = 1'b1;
          cmd_next = q_head;
          idx_next = '0;
          state_next = q_head.t_en ? ST_TCNT : (q_head.f_en ? ST_OCNT : ST_REND);
        end
      end
      ST_TCNT: begin
        if (can_load) begin
          emit      = 1'b1;
          emit_word = trre_pkg::COLOR_W'(cmd.t_cnt);
          emit_kind = trre_pkg::KIND_TCOUNT;
          emit_last = !cmd.f_en && !cmd.r_en;
          state_next = cmd.f_en ? ST_OCNT : (cmd.r_en ? ST_REND : ST_IDLE);
        end
      end
      ST_OCNT: begin
        if (can_load) begin
          emit      = 1'b1;
          emit_word = trre_pkg::COLOR_W'(cmd.f_cnt);
          emit_kind = trre_pkg::KIND_OCOUNT;
          state_next = ST_PIX;
        end
      end
      ST_PIX: begin
        if (can_load) begin
          emit      = 1'b1;
          emit_word = ram_rdata;
          emit_kind = trre_pkg::KIND_PIXEL;
          emit_last = pix_done && !cmd.r_en;
          if (pix_done) begin
            rel.valid  = 1'b1;
            rel.bank   = cmd.f_bank;
            state_next = cmd.r_en ? ST_REND : ST_IDLE;
          end else begin
            idx_next = idx + trre_pkg::CNT_W'(1);
          end
        end
      end
      ST_REND: begin
        if (can_load) begin
          emit       = 1'b1;
          emit_kind  = trre_pkg::KIND_ROWEND;
          emit_last  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // read address follows the next index so the word is ready when needed
  assign ram_rbank = cmd_next.f_bank;
  assign ram_ridx  = idx_next[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
    if (emit) begin
      m_tdata <= emit_word;
      m_tuser <= emit_kind;
      m_tlast <= emit_last;
    end
  end

endmodule

/* design/transparent_run_rle_encoder.sv */
// transparent-run rle encoder: pixel intake at one per cycle into a two-entry queue,
// words out at one per cycle while m_tready allows, with an idle state between the word groups of two pixels.
// first word of a pixel passes the queue, the back-end state register and the output register.
// intake stalls on a full queue, or outside an opaque run while the next bank still drains.
// reset (synchronous, active high) clears counters, queue, bank flags and output valid;
// the pixel buffer is not cleared and needs no clearing pass.
`include "assert_macros.svh"

module transparent_run_rle_encoder #(
  parameter int MAX_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [23:0] pixel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [23:0] word
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);

  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int DEPTH = 2 ** (AW + 1);

  logic                         q_full, q_push, q_pop, q_avail;
  trre_pkg::cmd_t               q_in, q_head;
  logic                         ram_we, ram_wbank, ram_rbank;
  logic [AW-1:0]                ram_widx, ram_ridx;
  logic [trre_pkg::COLOR_W-1:0] ram_wdata, ram_rdata;
  trre_pkg::release_t           rel;
  logic [1:0]                   pending;

  trre_front #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_in),
    .ram_we    (ram_we),
    .ram_wbank (ram_wbank),
    .ram_widx  (ram_widx),
    .ram_wdata (ram_wdata),
    .rel       (rel),
    .pending   (pending)
  );

  trre_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .head      (q_head)
  );

  trre_ram #(.WIDTH(trre_pkg::COLOR_W), .DEPTH(DEPTH)) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({ram_wbank, ram_widx}),
    .wdata (ram_wdata),
    .raddr ({ram_rbank, ram_ridx}),
    .rdata (ram_rdata)
  );

  trre_back #(.AW(AW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_avail   (q_avail),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .ram_rbank (ram_rbank),
    .ram_ridx  (ram_ridx),
    .ram_rdata (ram_rdata),
    .rel       (rel),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // a bank still being drained is never overwritten
  `TRRE_ASSERT(a_no_write_busy_bank, ram_we |-> !pending[ram_wbank], "write into draining bank")
  // only a bank handed to the back end can be handed back
  `TRRE_ASSERT(a_release_pending, rel.valid |-> pending[rel.bank], "release of idle bank")
  // row end always closes the words of its pixel
  `TRRE_ASSERT(a_rowend_last, (m_tvalid && m_tuser == trre_pkg::KIND_ROWEND) |-> m_tlast,
    "row end word without last")

endmodule
